// ===== hw/rtl/bra_pkg.sv =====
// ----------------------------------------------------------------------------
// bra_pkg: types and constants of the bitmap run allocator
// Request and response layouts, operation and status codes, and the
// controller state encoding.
// ----------------------------------------------------------------------------
package bra_pkg;

	// Field widths fixed by the request and response formats.
	localparam int IDX_W  = 12;
	localparam int CNT_W  = 13;
	localparam int CFG_W  = 10;
	localparam int BYTE_W = 10;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_BIT   = 2'd1,
		OP_RUN   = 2'd2,
		OP_SCAN  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] first_bit;
		logic [CNT_W-1:0] run_length;
		logic             set_value;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] start_index;
	} rsp_t;

endpackage

// ===== hw/rtl/bra_ram.sv =====
// ----------------------------------------------------------------------------
// bra_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bitmap_run_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_allocator: first-fit bitmap allocator
// Keeps allocation marks in a byte RAM and serves clear-all, single-bit
// write, run write and first-fit scan requests, one response per request.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  bra_pkg::req_t
// rsp       out        rsp_valid / rsp_stall  bra_pkg::rsp_t
// cfg       in         cfg_wen                cfg_wdata (bytes_in_use)
//
// One request is in work at a time; the RAM port handles one byte per cycle.
// A run or bit write reads, merges and writes back each byte of its span, a
// scan reads bytes up to bytes_in_use, and a clear-all writes zero to all
// MAX_BYTES bytes. After reset a clearing pass over all MAX_BYTES bytes runs
// before the first request transfer. A new request is taken while a response
// waits on a stalled output; the next response waits for the output register.
//
module bitmap_run_allocator #(
	parameter int MAX_BYTES = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  bra_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output bra_pkg::rsp_t                  rsp,
	input  logic                           cfg_wen,
	input  logic [bra_pkg::CFG_W-1:0]      cfg_wdata
);

	import bra_pkg::*;

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	// Control registers.
	state_t            state_q, state_d;
	logic [CFG_W-1:0]  cfg_q;
	logic [AW-1:0]     clr_addr_q;
	logic              pend_q;
	logic              rd_more_q;
	logic              rd_vld_s1;
	logic              rsp_valid_q;

	// Payload registers.
	logic [BYTE_W-1:0] rd_ptr_q;
	logic [BYTE_W-1:0] rd_addr_s1;
	logic [BYTE_W-1:0] runf_q;
	logic [BYTE_W-1:0] last_q;
	logic [2:0]        lo_q;
	logic [2:0]        hi_q;
	logic              val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  zeros_q;
	logic [CNT_W-1:0]  first_q;
	status_t           res_status_q;
	logic [IDX_W-1:0]  res_start_q;
	rsp_t              rsp_q;

	// RAM port signals.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [7:0]        ram_rdata;

	// Request decode.
	logic              req_xfer;
	logic [CNT_W-1:0]  req_cnt;
	logic [CNT_W+0:0]  end_excl;
	logic [CNT_W+0:0]  end_m1;
	logic              range_bad;
	logic [BYTE_W-1:0] eff_bytes;
	logic [CNT_W-1:0]  limit;
	logic [BYTE_W-1:0] stop_byte;
	logic              out_free;

	// Byte merge and scan step.
	logic [2:0]        lo_b;
	logic [2:0]        hi_b;
	logic [7:0]        mask;
	logic [7:0]        merged;
	logic [CNT_W-1:0]  zc;
	logic [CNT_W-1:0]  fc;
	logic              hit;
	logic              run_end;
	logic              scan_last;

	assign req_stall = (state_q != ST_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Length in use, capped at the store size.
	always_comb begin
		if ({7'd0, cfg_q} > 17'(MAX_BYTES)) begin
			eff_bytes = BYTE_W'(MAX_BYTES);
		end else begin
			eff_bytes = cfg_q;
		end
	end
	assign limit = {eff_bytes, 3'd0};

	// Range check for bit and run writes; a bit write is a run of one.
	assign req_cnt   = (req.operation == OP_BIT) ? CNT_W'(1) : req.run_length;
	assign end_excl  = {2'd0, req.first_bit} + {1'b0, req_cnt};
	assign end_m1    = end_excl - 14'd1;
	assign range_bad = end_excl > {1'b0, limit};

	assign stop_byte = (state_q == ST_RUN) ? last_q : (eff_bytes - BYTE_W'(1));
	assign run_end   = rd_vld_s1 && (rd_addr_s1 == last_q);
	assign scan_last = rd_vld_s1 && (rd_addr_s1 == (eff_bytes - BYTE_W'(1)));

	// Bit mask of the run inside the byte being written back.
	always_comb begin
		lo_b   = (rd_addr_s1 == runf_q) ? lo_q : 3'd0;
		hi_b   = (rd_addr_s1 == last_q) ? hi_q : 3'd7;
		mask   = (8'hFF << lo_b) & (8'hFF >> (3'd7 - hi_b));
		merged = val_q ? (ram_rdata | mask) : (ram_rdata & ~mask);
	end

	// Scan step over the eight bits of one byte, lowest bit first.
	always_comb begin
		zc  = zeros_q;
		fc  = first_q;
		hit = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if (!hit) begin
				if (!ram_rdata[j]) begin
					if (zc == '0) begin
						fc = {rd_addr_s1, 3'(j)};
					end
					zc = zc + CNT_W'(1);
					if (zc == cnt_q) begin
						hit = 1'b1;
					end
				end else begin
					zc = '0;
				end
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == AW'(MAX_BYTES - 1)) begin
					state_d = pend_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_xfer) begin
					case (req.operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_BIT, OP_RUN: begin
							state_d = (range_bad || req_cnt == '0) ? ST_DONE : ST_RUN;
						end
						OP_SCAN: begin
							state_d = (req.run_length == '0 || eff_bytes == '0) ?
								ST_DONE : ST_SCAN;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RUN: begin
				if (run_end) begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				if (rd_vld_s1 && (hit || scan_last)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control per state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(rd_addr_s1);
		ram_wdata = merged;
		ram_re    = 1'b0;
		ram_raddr = AW'(rd_ptr_q);
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = 8'h00;
			end
			ST_RUN: begin
				ram_re = rd_more_q;
				ram_we = rd_vld_s1;
			end
			ST_SCAN: begin
				ram_re = rd_more_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cfg_q       <= CFG_W'(512);
			clr_addr_q  <= '0;
			pend_q      <= 1'b0;
			rd_more_q   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (req_xfer && req.operation == OP_CLEAR) begin
				clr_addr_q <= '0;
				pend_q     <= 1'b1;
			end else if (state_q == ST_DONE) begin
				pend_q <= 1'b0;
			end
			if (req_xfer) begin
				rd_more_q <= 1'b1;
			end else if (state_d == ST_DONE) begin
				rd_more_q <= 1'b0;
			end else if (ram_re) begin
				rd_more_q <= (rd_ptr_q != stop_byte);
			end
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_ptr_q;
		if (ram_re) begin
			rd_ptr_q <= rd_ptr_q + BYTE_W'(1);
		end
		if (req_xfer) begin
			runf_q      <= BYTE_W'(req.first_bit >> 3);
			last_q      <= end_m1[12:3];
			lo_q        <= req.first_bit[2:0];
			hi_q        <= end_m1[2:0];
			val_q       <= req.set_value;
			cnt_q       <= req.run_length;
			zeros_q     <= '0;
			first_q     <= '0;
			res_start_q <= '0;
			res_status_q <= STAT_DONE;
			if (req.operation == OP_SCAN) begin
				rd_ptr_q <= '0;
				if (state_d == ST_DONE) begin
					res_status_q <= STAT_NOTFOUND;
				end
			end else begin
				rd_ptr_q <= BYTE_W'(req.first_bit >> 3);
				if (req.operation != OP_CLEAR && range_bad) begin
					res_status_q <= STAT_RANGE;
				end
			end
		end
		// Scan bookkeeping and its result.
		if (state_q == ST_SCAN && rd_vld_s1) begin
			zeros_q <= zc;
			first_q <= fc;
			if (hit) begin
				res_status_q <= STAT_DONE;
				res_start_q  <= fc[IDX_W-1:0];
			end else if (scan_last) begin
				res_status_q <= STAT_NOTFOUND;
			end
		end
		// Load the response register when it is free.
		if (state_q == ST_DONE && out_free) begin
			rsp_q.status      <= res_status_q;
			rsp_q.start_index <= res_start_q;
		end
	end

	bra_ram #(
		.WIDTH (8),
		.DEPTH (MAX_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A scan never writes the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_we)
		else $error("store written during a scan");

	// Run write-backs stay inside the byte span of the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && rd_vld_s1) |->
			(rd_addr_s1 >= runf_q && rd_addr_s1 <= last_q))
		else $error("run write-back outside its span");

	// Scanned bytes lie inside the length in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && rd_vld_s1) |-> (rd_addr_s1 < eff_bytes))
		else $error("scan read beyond the length in use");

	// A found start lies inside the scanned bits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_status_q == STAT_DONE) |->
			(res_start_q == '0 || {1'b0, res_start_q} < limit))
		else $error("found start beyond the length in use");

endmodule
